FILE: hw/rtl/gbn_pkg.sv
`default_nettype none

package gbn_pkg;

    localparam int SEQ_BITS = 5;
    localparam int CNT_BITS = 6;
    localparam int TAG_BITS = 16;
    localparam int UPC_BITS = 4;
    localparam int SEQ_MAX  = 31;

    typedef logic [SEQ_BITS-1:0] t_seq;
    typedef logic [CNT_BITS-1:0] t_cnt;
    typedef logic [TAG_BITS-1:0] t_tag;
    typedef logic [UPC_BITS-1:0] t_upc;

    localparam logic [2:0] KIND_PACKET   = 3'd0;
    localparam logic [2:0] KIND_PHY      = 3'd1;
    localparam logic [2:0] KIND_FRAME    = 3'd2;
    localparam logic [2:0] KIND_DATA_TO  = 3'd3;
    localparam logic [2:0] KIND_ACK_TO   = 3'd4;

    localparam logic [2:0] ACT_DATA      = 3'd0;
    localparam logic [2:0] ACT_ACK       = 3'd1;
    localparam logic [2:0] ACT_DELIVER   = 3'd2;
    localparam logic [2:0] ACT_STOP      = 3'd3;
    localparam logic [2:0] ACT_STATUS    = 3'd4;

    localparam logic FTYPE_DATA = 1'b0;

    typedef struct packed {
        logic [2:0] kind;
        t_tag       packet_tag;
        logic       frame_good;
        logic       frame_type;
        t_seq       rx_seq;
        t_seq       rx_ack;
    } t_in_word;

    typedef struct packed {
        logic [2:0] action;
        t_seq       seq;
        t_seq       ack;
        t_tag       tag;
        logic       network_enable;
        logic       last;
    } t_out_word;

    // microcode
    localparam t_upc UA_IDLE = 4'd0;
    localparam t_upc UA_PKT  = 4'd1;
    localparam t_upc UA_PHY  = 4'd2;
    localparam t_upc UA_RX   = 4'd3;
    localparam t_upc UA_RXD  = 4'd4;
    localparam t_upc UA_REL  = 4'd5;
    localparam t_upc UA_DTO  = 4'd6;
    localparam t_upc UA_RSND = 4'd7;
    localparam t_upc UA_ATO  = 4'd8;
    localparam t_upc UA_STAT = 4'd9;

    typedef enum logic [2:0] {
        C_ALWAYS,
        C_IN,
        C_WIN_OK,
        C_GOOD,
        C_DELIVER,
        C_RELEASE,
        C_RESEND
    } t_cond;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_NEW,
        OP_PHY_SET,
        OP_EXP_INC,
        OP_RELEASE,
        OP_REWIND,
        OP_RESEND,
        OP_ACK
    } t_op;

    typedef enum logic [1:0] {
        TS_ZERO,
        TS_INPUT,
        TS_STORE
    } t_tag_sel;

    typedef struct packed {
        logic       emit;
        logic [2:0] action;
        t_tag_sel   tag_sel;
        t_cond      cond;
        t_op        op;
        logic       dispatch;
        t_upc       next_t;
        t_upc       next_f;
    } t_uword;

    function automatic t_uword mk_uword(input logic emit, input logic [2:0] action,
                                        input t_tag_sel tag_sel, input t_cond cond,
                                        input t_op op, input logic dispatch,
                                        input t_upc next_t, input t_upc next_f);
        t_uword w;
        w.emit     = emit;
        w.action   = action;
        w.tag_sel  = tag_sel;
        w.cond     = cond;
        w.op       = op;
        w.dispatch = dispatch;
        w.next_t   = next_t;
        w.next_f   = next_f;
        return w;
    endfunction

    function automatic t_uword ucode(input t_upc a);
        t_uword w;
        unique case (a)
            UA_IDLE: w = mk_uword(1'b0, ACT_STATUS, TS_ZERO, C_IN, OP_LOAD, 1'b1,
                                  UA_IDLE, UA_IDLE);
            UA_PKT:  w = mk_uword(1'b1, ACT_DATA, TS_INPUT, C_WIN_OK, OP_NEW, 1'b0,
                                  UA_STAT, UA_STAT);
            UA_PHY:  w = mk_uword(1'b0, ACT_STATUS, TS_ZERO, C_ALWAYS, OP_PHY_SET, 1'b0,
                                  UA_STAT, UA_STAT);
            UA_RX:   w = mk_uword(1'b0, ACT_STATUS, TS_ZERO, C_GOOD, OP_NONE, 1'b0,
                                  UA_RXD, UA_STAT);
            UA_RXD:  w = mk_uword(1'b1, ACT_DELIVER, TS_INPUT, C_DELIVER, OP_EXP_INC, 1'b0,
                                  UA_REL, UA_REL);
            UA_REL:  w = mk_uword(1'b1, ACT_STOP, TS_ZERO, C_RELEASE, OP_RELEASE, 1'b0,
                                  UA_REL, UA_STAT);
            UA_DTO:  w = mk_uword(1'b0, ACT_STATUS, TS_ZERO, C_ALWAYS, OP_REWIND, 1'b0,
                                  UA_RSND, UA_RSND);
            UA_RSND: w = mk_uword(1'b1, ACT_DATA, TS_STORE, C_RESEND, OP_RESEND, 1'b0,
                                  UA_RSND, UA_STAT);
            UA_ATO:  w = mk_uword(1'b1, ACT_ACK, TS_ZERO, C_ALWAYS, OP_ACK, 1'b0,
                                  UA_STAT, UA_STAT);
            UA_STAT: w = mk_uword(1'b1, ACT_STATUS, TS_ZERO, C_ALWAYS, OP_NONE, 1'b0,
                                  UA_IDLE, UA_IDLE);
            default: w = mk_uword(1'b0, ACT_STATUS, TS_ZERO, C_ALWAYS, OP_NONE, 1'b0,
                                  UA_IDLE, UA_IDLE);
        endcase
        return w;
    endfunction

    function automatic t_upc entry_of(input logic [2:0] kind);
        t_upc a;
        unique case (kind)
            KIND_PACKET:  a = UA_PKT;
            KIND_PHY:     a = UA_PHY;
            KIND_FRAME:   a = UA_RX;
            KIND_DATA_TO: a = UA_DTO;
            KIND_ACK_TO:  a = UA_ATO;
            default:      a = UA_STAT;
        endcase
        return a;
    endfunction

    // b in circular interval [a, c)
    function automatic logic in_window(input t_seq a, input t_seq b, input t_seq c);
        return ((a <= b) && (b < c)) || ((c < a) && (a <= b)) || ((b < c) && (c < a));
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/gbn_store.sv
`default_nettype none

module gbn_store (
    input  logic                             i_clk,
    input  logic                             i_wr_en,
    input  logic [gbn_pkg::SEQ_BITS-1:0]     i_wr_addr,
    input  logic [gbn_pkg::TAG_BITS-1:0]     i_wr_data,
    input  logic [gbn_pkg::SEQ_BITS-1:0]     i_rd_addr,
    output logic [gbn_pkg::TAG_BITS-1:0]     o_rd_data
);
    import gbn_pkg::*;

    localparam int Depth = 1 << SEQ_BITS;

    t_tag r_mem [Depth];
    t_tag r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

FILE: hw/rtl/go_back_n_link_controller_core.sv
`default_nettype none

// channel | signals                              | direction
// in      | i_in_valid, o_in_ready, i_in_word    | event word into the block
// out     | o_out_valid, i_out_ready, o_out_word | command word out of the block
//
// Without stalls the sequencer runs one microinstruction per cycle; an event of
// unknown kind goes straight to the status step, and the release loop of a good
// frame and the resend loop of a data timeout run once per frame, up to 31 frames.
// One event is in flight at a time; o_in_ready is high while the sequencer idles.
// A full output register holds the sequencer on its emitting step.
// Reset clears sequence state and the phy flag; the packet store is not cleared.

module go_back_n_link_controller_core #(
    parameter int WINDOW_MAX = 31
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  gbn_pkg::t_in_word   i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output gbn_pkg::t_out_word  o_out_word
);
    import gbn_pkg::*;

    localparam int WinLimit = (WINDOW_MAX < SEQ_MAX) ? WINDOW_MAX : SEQ_MAX;

    t_upc      r_upc, n_upc;
    t_seq      r_nss, n_nss;
    t_seq      r_oldest, n_oldest;
    t_seq      r_exp, n_exp;
    t_cnt      r_cnt, n_cnt;
    t_cnt      r_k, n_k;
    logic      r_phy, n_phy;
    logic      r_out_valid, n_out_valid;
    t_in_word  r_in;
    t_out_word r_out, n_out;

    t_uword    uw;
    logic      cond_ok;
    logic      out_free;
    logic      fire;
    logic      win_ok;
    logic      st_wr_en;
    t_tag      st_rd_data;
    t_tag      tag_val;

    assign uw       = ucode(r_upc);
    assign out_free = !r_out_valid || i_out_ready;
    assign win_ok   = r_cnt < CNT_BITS'(WinLimit);

    always_comb begin
        unique case (uw.cond)
            C_ALWAYS:  cond_ok = 1'b1;
            C_IN:      cond_ok = i_in_valid;
            C_WIN_OK:  cond_ok = win_ok;
            C_GOOD:    cond_ok = r_in.frame_good;
            C_DELIVER: cond_ok = (r_in.frame_type == FTYPE_DATA) && (r_in.rx_seq == r_exp);
            C_RELEASE: cond_ok = (r_cnt != '0) && in_window(r_oldest, r_in.rx_ack, r_nss);
            C_RESEND:  cond_ok = r_k < r_cnt;
            default:   cond_ok = 1'b0;
        endcase
    end

    assign fire = cond_ok && (!uw.emit || out_free);

    always_comb begin
        case (uw.tag_sel)
            TS_INPUT: tag_val = r_in.packet_tag;
            TS_STORE: tag_val = st_rd_data;
            default:  tag_val = '0;
        endcase
    end

    always_comb begin
        n_out = '0;
        n_out.action = uw.action;
        unique case (uw.action)
            ACT_DATA: begin
                n_out.seq = r_nss;
                n_out.ack = r_exp - SEQ_BITS'(1);
                n_out.tag = tag_val;
            end
            ACT_ACK: begin
                n_out.seq = r_nss;
                n_out.ack = r_exp - SEQ_BITS'(1);
            end
            ACT_DELIVER: begin
                n_out.tag = tag_val;
            end
            ACT_STOP: begin
                n_out.seq = r_oldest;
            end
            ACT_STATUS: begin
                n_out.network_enable = win_ok && r_phy;
                n_out.last           = 1'b1;
            end
            default: begin
                n_out.action = ACT_STATUS;
            end
        endcase
    end

    always_comb begin
        n_upc       = r_upc;
        n_nss       = r_nss;
        n_oldest    = r_oldest;
        n_exp       = r_exp;
        n_cnt       = r_cnt;
        n_k         = r_k;
        n_phy       = r_phy;
        n_out_valid = r_out_valid && !i_out_ready;
        st_wr_en    = 1'b0;
        if (!cond_ok) begin
            n_upc = uw.next_f;
        end else if (fire) begin
            n_upc = uw.dispatch ? entry_of(i_in_word.kind) : uw.next_t;
            if (uw.emit) begin
                n_out_valid = 1'b1;
            end
            unique case (uw.op) inside
                OP_NONE, OP_LOAD: begin
                end
                OP_NEW: begin
                    st_wr_en = 1'b1;
                    n_cnt    = r_cnt + CNT_BITS'(1);
                    n_nss    = r_nss + SEQ_BITS'(1);
                    n_phy    = 1'b0;
                end
                OP_PHY_SET: n_phy = 1'b1;
                OP_EXP_INC: n_exp = r_exp + SEQ_BITS'(1);
                OP_RELEASE: begin
                    n_cnt    = r_cnt - CNT_BITS'(1);
                    n_oldest = r_oldest + SEQ_BITS'(1);
                end
                OP_REWIND: begin
                    n_nss = r_oldest;
                    n_k   = '0;
                end
                OP_RESEND: begin
                    n_nss = r_nss + SEQ_BITS'(1);
                    n_k   = r_k + CNT_BITS'(1);
                    n_phy = 1'b0;
                end
                OP_ACK: n_phy = 1'b0;
                default: begin
                end
            endcase
        end
    end

    // read at the next send pointer so the entry for r_nss is ready each cycle
    gbn_store u_store (
        .i_clk     (i_clk),
        .i_wr_en   (st_wr_en),
        .i_wr_addr (r_nss),
        .i_wr_data (r_in.packet_tag),
        .i_rd_addr (n_nss),
        .o_rd_data (st_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc       <= UA_IDLE;
            r_nss       <= '0;
            r_oldest    <= '0;
            r_exp       <= '0;
            r_cnt       <= '0;
            r_k         <= '0;
            r_phy       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_upc       <= n_upc;
            r_nss       <= n_nss;
            r_oldest    <= n_oldest;
            r_exp       <= n_exp;
            r_cnt       <= n_cnt;
            r_k         <= n_k;
            r_phy       <= n_phy;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && uw.op == OP_LOAD) begin
            r_in <= i_in_word;
        end
        if (fire && uw.emit) begin
            r_out <= n_out;
        end
    end

    assign o_in_ready  = (r_upc == UA_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

`ifndef SYNTH
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_BITS'(SEQ_MAX))
        else $error("outstanding count above 31");

    a_idle_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_upc == UA_IDLE) |-> (r_cnt[SEQ_BITS-1:0] == SEQ_BITS'(r_nss - r_oldest)))
        else $error("outstanding count disagrees with window pointers");

    a_resend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_upc == UA_RSND) |-> (r_k <= r_cnt))
        else $error("resend index past outstanding count");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> (r_out_valid && $stable(r_out)))
        else $error("pending output word overwritten");
`endif

endmodule

`default_nettype wire
